// File: hw/rtl/gst_pkg.sv
`default_nettype none

package gst_pkg;

  // field widths
  localparam int unsigned PosW        = 16;
  localparam int unsigned DeltaW      = PosW + 1;
  localparam int unsigned SqW         = 2 * DeltaW;
  localparam int unsigned ThreshW     = 30;
  localparam int unsigned DirW        = 4;
  localparam int unsigned CountOutW   = 2;
  localparam int unsigned InDataW     = 32;
  localparam int unsigned InUserW     = 2;
  localparam int unsigned OutDataW    = 16;

  // defaults
  localparam logic [ThreshW-1:0] ThreshReset    = 30'd10000;
  localparam int unsigned        MaxStrokesDflt = 3;

  // event kinds carried in tuser
  typedef enum logic [1:0] {
    CMD_MOVE    = 2'd0,
    CMD_PRESS   = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_IGNORE  = 2'd3
  } cmd_e;

  // stroke direction codes, two's complement, none is minus one
  localparam logic [DirW-1:0] DirUp        = 4'd0;
  localparam logic [DirW-1:0] DirDown      = 4'd1;
  localparam logic [DirW-1:0] DirLeft      = 4'd2;
  localparam logic [DirW-1:0] DirRight     = 4'd3;
  localparam logic [DirW-1:0] DirUpLeft    = 4'd4;
  localparam logic [DirW-1:0] DirDownLeft  = 4'd5;
  localparam logic [DirW-1:0] DirUpRight   = 4'd6;
  localparam logic [DirW-1:0] DirDownRight = 4'd7;
  localparam logic [DirW-1:0] DirNone      = 4'hF;

  // one result item, packed lowest field last so tdata order matches
  typedef struct packed {
    logic                 is_tracking;
    logic                 aborted;
    logic [CountOutW-1:0] stroke_count;
    logic                 stroke_added;
    logic [DirW-1:0]      last_direction;
  } res_t;

endpackage

`default_nettype wire

// File: hw/rtl/gst_classify.sv
`default_nettype none

module gst_classify
  import gst_pkg::*;
(
  input  wire logic signed [PosW-1:0]    pos_x_i,
  input  wire logic signed [PosW-1:0]    pos_y_i,
  input  wire logic signed [PosW-1:0]    anchor_x_i,
  input  wire logic signed [PosW-1:0]    anchor_y_i,
  input  wire logic        [ThreshW-1:0] thresh_i,
  output logic                           exceed_o,
  output logic             [DirW-1:0]    dir_o
);

  logic signed [DeltaW-1:0] dx, dy;
  logic        [DeltaW-1:0] ax, ay;
  logic signed [SqW-1:0]    sq_x, sq_y;
  logic        [SqW:0]      dist_sq;
  logic                     diag, horiz;

  // offset from the anchor
  assign dx = {pos_x_i[PosW-1], pos_x_i} - {anchor_x_i[PosW-1], anchor_x_i};
  assign dy = {pos_y_i[PosW-1], pos_y_i} - {anchor_y_i[PosW-1], anchor_y_i};
  assign ax = dx[DeltaW-1] ? DeltaW'(-dx) : DeltaW'(dx);
  assign ay = dy[DeltaW-1] ? DeltaW'(-dy) : DeltaW'(dy);

  // squared distance against threshold
  assign sq_x    = dx * dx;
  assign sq_y    = dy * dy;
  assign dist_sq = {1'b0, sq_x} + {1'b0, sq_y};
  assign exceed_o = dist_sq > {{(SqW + 1 - ThreshW){1'b0}}, thresh_i};

  // diagonal when each axis is below twice the other
  assign diag  = ({1'b0, ay} < {ax, 1'b0}) && ({1'b0, ax} < {ay, 1'b0});
  assign horiz = {1'b0, ax} >= {ay, 1'b0};

  always_comb begin
    priority if (diag) begin
      priority if (!dx[DeltaW-1] && !dy[DeltaW-1]) dir_o = DirDownRight;
      else if (!dx[DeltaW-1]) dir_o = DirUpRight;
      else if (!dy[DeltaW-1]) dir_o = DirDownLeft;
      else dir_o = DirUpLeft;
    end else if (horiz) begin
      dir_o = (dx > 0) ? DirRight : DirLeft;
    end else begin
      dir_o = (dy > 0) ? DirDown : DirUp;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/gst_track.sv
`default_nettype none

module gst_track
  import gst_pkg::*;
#(
  parameter int unsigned MaxStrokes = MaxStrokesDflt
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       step_i,
  input  wire cmd_e                       cmd_i,
  input  wire logic signed [PosW-1:0]    pos_x_i,
  input  wire logic signed [PosW-1:0]    pos_y_i,
  input  wire logic        [ThreshW-1:0] thresh_i,
  output res_t                            res_o
);

  localparam int unsigned CntBits = $clog2(MaxStrokes + 1);
  localparam int unsigned CntW    = (CntBits > CountOutW) ? CntBits : CountOutW;

  logic                    trk_q, trk_d;
  logic                    abt_q, abt_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [DirW-1:0]         prev_q, prev_d;
  logic signed [PosW-1:0]  anc_x_q, anc_x_d, anc_y_q, anc_y_d;
  logic [CntW:0]           cnt_inc;
  logic                    exceed, check, moved, added;
  logic [DirW-1:0]         dir;

  gst_classify u_classify (
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .anchor_x_i (anc_x_q),
    .anchor_y_i (anc_y_q),
    .thresh_i   (thresh_i),
    .exceed_o   (exceed),
    .dir_o      (dir)
  );

  assign cnt_inc = {1'b0, cnt_q} + 1'b1;

  // next gesture state for the item in the input register
  always_comb begin
    trk_d   = trk_q;
    abt_d   = abt_q;
    cnt_d   = cnt_q;
    prev_d  = prev_q;
    anc_x_d = anc_x_q;
    anc_y_d = anc_y_q;
    unique case (cmd_i)
      CMD_PRESS:   trk_d = 1'b1;
      CMD_RELEASE: begin
        trk_d = 1'b0;
        abt_d = 1'b0;
        cnt_d = '0;
      end
      CMD_MOVE, CMD_IGNORE: ;
      default: ;
    endcase
    check = (cmd_i != CMD_IGNORE) && trk_d && !abt_d;
    moved = check && exceed;
    added = moved && (dir != prev_q);
    if (added) begin
      if (cnt_inc > (CntW + 1)'(MaxStrokes)) begin
        abt_d  = 1'b1;
        cnt_d  = '0;
        prev_d = DirNone;
      end else begin
        cnt_d  = cnt_inc[CntW-1:0];
        prev_d = dir;
      end
    end
    if (moved) begin
      anc_x_d = pos_x_i;
      anc_y_d = pos_y_i;
    end
    res_o.last_direction = prev_d;
    res_o.stroke_added   = added;
    res_o.stroke_count   = cnt_d[CountOutW-1:0];
    res_o.aborted        = abt_d;
    res_o.is_tracking    = trk_d;
  end

  // state registers, advanced once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trk_q   <= 1'b0;
      abt_q   <= 1'b0;
      cnt_q   <= '0;
      prev_q  <= DirNone;
      anc_x_q <= '0;
      anc_y_q <= '0;
    end else if (step_i) begin
      trk_q   <= trk_d;
      abt_q   <= abt_d;
      cnt_q   <= cnt_d;
      prev_q  <= prev_d;
      anc_x_q <= anc_x_d;
      anc_y_q <= anc_y_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/pointer_gesture_stroke_tracker_core.sv
// path: an input item is registered in the input register, then its result in the
//   result register once that is free or drained
// throughput: 1 item per cycle unless results stall; the gesture state feeds back through
//   one pass of subtract, square, compare and direction classify between the two registers
// reset: asynchronous active low; not tracking, no strokes, direction none,
//   anchor at origin, threshold 10000, both channels empty
`default_nettype none

module pointer_gesture_stroke_tracker_core
  import gst_pkg::*;
#(
  parameter int unsigned MaxStrokes = MaxStrokesDflt
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration write: distance squared threshold
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [ThreshW-1:0]  cfg_data_i,
  // input items
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,  // pos_x [15:0], pos_y [31:16]
  input  wire logic [InUserW-1:0]  s_axis_tuser,  // cmd [1:0]
  // result items
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata   // last_direction [3:0], stroke_added [4],
                                                  // stroke_count [6:5], aborted [7],
                                                  // is_tracking [8], zero [15:9]
);

  logic [ThreshW-1:0]      thresh_q;
  logic                    in_valid_q;
  cmd_e                    in_cmd_q;
  logic signed [PosW-1:0]  in_x_q, in_y_q;
  logic                    out_valid_q;
  res_t                    out_res_q;
  res_t                    res;
  logic                    step;

  // item moves to the result register when that is free or drained
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;
  assign cfg_ready_o   = 1'b1;

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ThreshReset;
    end else if (cfg_valid_i) begin
      thresh_q <= cfg_data_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd_q <= cmd_e'(s_axis_tuser[1:0]);
      in_x_q   <= s_axis_tdata[PosW-1:0];
      in_y_q   <= s_axis_tdata[2*PosW-1:PosW];
    end
  end

  gst_track #(
    .MaxStrokes (MaxStrokes)
  ) u_track (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .cmd_i    (in_cmd_q),
    .pos_x_i  (in_x_q),
    .pos_y_i  (in_y_q),
    .thresh_i (thresh_q),
    .res_o    (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(out_res_q);

endmodule

`default_nettype wire

// File: hw/rtl/gst_checker.sv
`default_nettype none

module gst_checker
  import gst_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  input  wire logic [OutDataW-1:0] m_axis_tdata
);

  // stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item changed under stall");

  // direction is none or one of the eight codes
  a_dir_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[3:0] == DirNone)
    else $error("bad direction code");

  // an aborted gesture reports no strokes
  a_abort_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[7] |-> m_axis_tdata[6:5] == 2'd0)
    else $error("stroke count nonzero while aborted");

  // idle pointer carries no gesture state
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[8] |->
      !m_axis_tdata[7] && !m_axis_tdata[4] && m_axis_tdata[6:5] == 2'd0)
    else $error("gesture state while not tracking");

  // a new stroke without abort leaves a direction set
  a_added_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[4] && !m_axis_tdata[7] |->
      m_axis_tdata[3:0] != DirNone)
    else $error("stroke added without direction");

endmodule

bind pointer_gesture_stroke_tracker_core gst_checker u_gst_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
